/* sv/assert_macros.svh */
// Assertion macros for the RTL of this block (used by round_to_multiple_modes).
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* sv/rtm_pkg.sv */
// Package for the rounding block: mode codes and the per-item record type.
// No dependencies.
`timescale 1ns / 1ps
package rtm_pkg;
  localparam logic [3:0] MODE_DEFAULT   = 4'd0;
  localparam logic [3:0] MODE_05UP      = 4'd1;
  localparam logic [3:0] MODE_CEILING   = 4'd2;
  localparam logic [3:0] MODE_DOWN      = 4'd3;
  localparam logic [3:0] MODE_FLOOR     = 4'd4;
  localparam logic [3:0] MODE_HALF_DOWN = 4'd5;
  localparam logic [3:0] MODE_HALF_EVEN = 4'd6;
  localparam logic [3:0] MODE_HALF_UP   = 4'd7;
  localparam logic [3:0] MODE_UP        = 4'd8;

  typedef struct packed {
    logic       negative;
    logic [3:0] func;
  } ctl_t;
endpackage

/* sv/round_to_multiple_modes.sv */
// Path: divider (one stage per quotient bit), mode decision stage, output register.
// Throughput: one beat per cycle while the output register is not stalled.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// Depends on rtm_pkg, rtm_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module round_to_multiple_modes #(
  parameter int VALUE_BITS = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [135:0]  in_tdata,  // magnitude[63:0], quantum[127:64], func[131:128], zeros
  input  logic          in_tuser,  // negative
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [63:0]   out_tdata,  // rounded
  output logic          out_tuser   // wrapped
);
  localparam int W = VALUE_BITS;

  logic           en;
  logic           dv;
  logic [W-1:0]   dq, drm, dn, dd;
  logic [2:0]     dq5;
  rtm_pkg::ctl_t  dc, in_ctl;

  logic           v1_r;
  logic [W-1:0]   n1_r, d1_r, rm1_r;
  logic           away1_r;
  logic           o_v_r;
  logic [63:0]    o_d_r;
  logic           o_w_r;

  assign en        = !o_v_r || out_tready;
  assign in_tready = en;
  assign in_ctl    = '{negative: in_tuser, func: in_tdata[131:128]};

  rtm_div #(.W(W)) u_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_tvalid && en),
    .in_num(in_tdata[W-1:0]), .in_den(in_tdata[64+W-1:64]), .in_ctl(in_ctl),
    .out_valid(dv), .out_quot(dq), .out_rem(drm), .out_q5(dq5), .out_num(dn),
    .out_den(dd), .out_ctl(dc)
  );

  // Mode decision stage.
  logic [W-1:0] other;
  logic         away_nxt;
  always_comb begin
    other    = dd - drm;
    away_nxt = 1'b0;
    if (dd != '0 && drm != '0) begin
      case (dc.func)
        rtm_pkg::MODE_05UP:      away_nxt = (dq5 == 3'd0);
        rtm_pkg::MODE_CEILING:   away_nxt = !dc.negative;
        rtm_pkg::MODE_FLOOR:     away_nxt = dc.negative;
        rtm_pkg::MODE_HALF_DOWN: away_nxt = drm > other;
        rtm_pkg::MODE_DEFAULT, rtm_pkg::MODE_HALF_EVEN:
          away_nxt = (drm > other) || (drm == other && dq[0]);
        rtm_pkg::MODE_HALF_UP:   away_nxt = drm >= other;
        rtm_pkg::MODE_UP:        away_nxt = 1'b1;
        default:                 away_nxt = 1'b0;
      endcase
    end
  end

  logic trunc1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= dv;
    end
    if (en) begin
      n1_r    <= dn;
      d1_r    <= dd;
      rm1_r   <= (dd != '0 && dc.func <= rtm_pkg::MODE_UP) ? drm : '0;
      away1_r <= away_nxt;
    end
  end
  assign trunc1 = 1'b0;

  // Final add or subtract stage.
  logic [W:0]   up_sum;
  logic [W-1:0] res_nxt;
  logic         wrap_nxt;
  always_comb begin
    up_sum = {1'b0, n1_r} + {1'b0, d1_r - rm1_r};
    if (away1_r) begin
      res_nxt  = up_sum[W-1:0];
      wrap_nxt = up_sum[W];
    end else begin
      res_nxt  = n1_r - rm1_r;
      wrap_nxt = trunc1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= v1_r;
    end
    if (en) begin
      o_d_r <= 64'(res_nxt);
      o_w_r <= wrap_nxt;
    end
  end

  assign out_tvalid = o_v_r;
  assign out_tdata  = o_d_r;
  assign out_tuser  = o_w_r;

  `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !o_v_r, in_tready)
  `ASSERT_IMPLY(a_no_wrap_trunc, clk, rst_n, v1_r && !away1_r, !wrap_nxt)
  `ASSERT_NEXT(a_hold_stall, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

/* sv/rtm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with stall support.
// Each stage also carries the quotient prefix modulo 5. Depends on rtm_pkg.
`timescale 1ns / 1ps
module rtm_div #(
  parameter int W = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [W-1:0]   in_num,
  input  logic [W-1:0]   in_den,
  input  rtm_pkg::ctl_t  in_ctl,
  output logic           out_valid,
  output logic [W-1:0]   out_quot,
  output logic [W-1:0]   out_rem,
  output logic [2:0]     out_q5,
  output logic [W-1:0]   out_num,
  output logic [W-1:0]   out_den,
  output rtm_pkg::ctl_t  out_ctl
);
  logic          v_r   [W+1];
  logic [W-1:0]  q_r   [W+1];
  logic [W:0]    rm_r  [W+1];
  logic [2:0]    r5_r  [W+1];
  logic [W-1:0]  n_r   [W+1];
  logic [W-1:0]  d_r   [W+1];
  rtm_pkg::ctl_t c_r   [W+1];

  always_comb begin
    v_r[0]  = in_valid;
    q_r[0]  = in_num;
    rm_r[0] = '0;
    r5_r[0] = '0;
    n_r[0]  = in_num;
    d_r[0]  = in_den;
    c_r[0]  = in_ctl;
  end

  for (genvar i = 0; i < W; i++) begin : g_st
    logic          v_s_r;
    logic [W-1:0]  q_s_r, n_s_r, d_s_r;
    logic [W:0]    rm_s_r;
    logic [2:0]    r5_s_r;
    rtm_pkg::ctl_t c_s_r;
    logic [W:0]    sh_nxt, df_nxt;
    logic [W-1:0]  q_nxt;
    logic [W:0]    rm_nxt;
    logic [3:0]    r5_x;
    logic [2:0]    r5_nxt;

    always_comb begin
      sh_nxt = {rm_r[i][W-1:0], q_r[i][W-1]};
      df_nxt = sh_nxt - {1'b0, d_r[i]};
      if (!df_nxt[W]) begin
        rm_nxt = df_nxt;
        q_nxt  = {q_r[i][W-2:0], 1'b1};
      end else begin
        rm_nxt = sh_nxt;
        q_nxt  = {q_r[i][W-2:0], 1'b0};
      end
      r5_x   = {r5_r[i], q_nxt[0]};
      r5_nxt = (r5_x >= 4'd5) ? 3'(r5_x - 4'd5) : r5_x[2:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s_r <= 1'b0;
      end else if (en) begin
        v_s_r <= v_r[i];
      end
      if (en) begin
        q_s_r  <= q_nxt;
        rm_s_r <= rm_nxt;
        r5_s_r <= r5_nxt;
        n_s_r  <= n_r[i];
        d_s_r  <= d_r[i];
        c_s_r  <= c_r[i];
      end
    end

    always_comb begin
      v_r[i+1]  = v_s_r;
      q_r[i+1]  = q_s_r;
      rm_r[i+1] = rm_s_r;
      r5_r[i+1] = r5_s_r;
      n_r[i+1]  = n_s_r;
      d_r[i+1]  = d_s_r;
      c_r[i+1]  = c_s_r;
    end
  end

  assign out_valid = v_r[W];
  assign out_quot  = q_r[W];
  assign out_rem   = rm_r[W][W-1:0];
  assign out_q5    = r5_r[W];
  assign out_num   = n_r[W];
  assign out_den   = d_r[W];
  assign out_ctl   = c_r[W];
endmodule

/* sim/tb_round_to_multiple_modes.sv */
// Testbench for round_to_multiple_modes: directed table, then random beats checked
// against an in-bench rounding predictor. Depends on rtm_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb_round_to_multiple_modes;
  localparam int LAT = 66;
  localparam int WDOG_LIMIT = 20000;
  localparam int N_RANDOM = 830;
  localparam logic [3:0] MODE_UNKNOWN_LO = 4'd9;
  localparam logic [3:0] MODE_UNKNOWN_HI = 4'd15;

  typedef struct {
    logic        negative;
    logic [63:0] magnitude;
    logic [63:0] quantum;
    logic [3:0]  func;
    logic        has_exp;
    logic [63:0] exp_rounded;
    logic        exp_wrapped;
  } vec_t;

  typedef struct {
    logic [63:0] rounded;
    logic        wrapped;
  } res_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [135:0] in_tdata = '0;
  logic in_tuser = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [63:0] out_tdata;
  logic out_tuser;

  res_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int idle_cycles = 0;
  bit stim_done = 0;
  bit rx_idle_on = 1;
  bit rx_holdoff = 0;
  bit tx_idle_on = 1;

  round_to_multiple_modes i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic res_t round_value(logic neg, logic [63:0] mag, logic [63:0] q,
                                       logic [3:0] mode);
    res_t r;
    logic [63:0] rem, quot, other;
    logic up;
    r.rounded = mag;
    r.wrapped = 0;
    if (q != 0 && mode <= rtm_pkg::MODE_UP) begin
      rem = mag % q;
      if (rem != 0) begin
        quot = mag / q;
        other = q - rem;
        case (mode)
          rtm_pkg::MODE_05UP:      up = (quot % 5) == 0;
          rtm_pkg::MODE_CEILING:   up = !neg;
          rtm_pkg::MODE_DOWN:      up = 0;
          rtm_pkg::MODE_FLOOR:     up = neg;
          rtm_pkg::MODE_HALF_DOWN: up = rem > other;
          rtm_pkg::MODE_DEFAULT, rtm_pkg::MODE_HALF_EVEN:
            up = rem > other || (rem == other && quot[0]);
          rtm_pkg::MODE_HALF_UP:   up = rem >= other;
          rtm_pkg::MODE_UP:        up = 1;
          default:                 up = 0;
        endcase
        if (up) begin
          r.rounded = mag + other;
          r.wrapped = r.rounded < mag;
        end else begin
          r.rounded = mag - rem;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch beat %0d: %s got %h expected %h", n_checked, what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_beat(vec_t v);
    res_t r;
    r = round_value(v.negative, v.magnitude, v.quantum, v.func);
    if (v.has_exp) begin
      if (r.rounded !== v.exp_rounded) report_mismatch("table rounded", r.rounded,
                                                       v.exp_rounded);
      if (r.wrapped !== v.exp_wrapped) report_mismatch("table wrapped", 64'(r.wrapped),
                                                       64'(v.exp_wrapped));
      r.rounded = v.exp_rounded;
      r.wrapped = v.exp_wrapped;
    end
    while (tx_idle_on && $urandom_range(99) < 29) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= v.negative;
    in_tdata <= {4'b0, v.func, v.quantum, v.magnitude};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(r);
    n_sent++;
  endtask

  function automatic vec_t mk(logic n, logic [63:0] m, logic [63:0] q, logic [3:0] f,
                              logic h = 0, logic [63:0] er = 0, logic ew = 0);
    vec_t v;
    v.negative = n; v.magnitude = m; v.quantum = q; v.func = f;
    v.has_exp = h; v.exp_rounded = er; v.exp_wrapped = ew;
    return v;
  endfunction

  function automatic vec_t rand_beat();
    logic [63:0] q, m;
    logic [3:0] f;
    case ($urandom_range(5))
      0: q = rand64();
      1: q = 64'(1) << $urandom_range(63);
      2: q = $urandom_range(1, 20);
      3: q = rand64() >> $urandom_range(63);
      4: q = 10 ** $urandom_range(1, 18);
      default: q = $urandom_range(1, 1000);
    endcase
    if (q == 0) q = 1;
    case ($urandom_range(4))
      0: m = rand64();
      1: m = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 1000);
      2: m = q * $urandom_range(0, 50) + (q >> 1) + $urandom_range(0, 1) - 1;
      3: m = rand64() >> $urandom_range(63);
      default: m = $urandom_range(0, 100000);
    endcase
    f = ($urandom_range(9) == 0) ? 4'($urandom_range(MODE_UNKNOWN_LO, MODE_UNKNOWN_HI)) :
                                   4'($urandom_range(rtm_pkg::MODE_DEFAULT, rtm_pkg::MODE_UP));
    return mk($urandom_range(1), m, q, f);
  endfunction

  vec_t dir_table[$];

  initial begin
    logic [63:0] max64;
    max64 = '1;
    dir_table = '{
      mk(0, 0, 1, rtm_pkg::MODE_UP, 1, 0, 0),
      mk(0, 100, 10, rtm_pkg::MODE_UP, 1, 100, 0),
      mk(0, max64, max64, rtm_pkg::MODE_UP, 1, max64, 0),
      mk(0, max64, 64'h8000_0000_0000_0000, rtm_pkg::MODE_UP, 1, 0, 1),
      mk(1, max64, 2, rtm_pkg::MODE_DOWN, 1, max64 - 1, 0),
      mk(0, 17, 0, rtm_pkg::MODE_UP, 1, 17, 0),
      mk(0, 17, 5, MODE_UNKNOWN_LO, 1, 17, 0),
      mk(1, 17, 5, MODE_UNKNOWN_HI, 1, 17, 0),
      mk(0, 17, 5, rtm_pkg::MODE_CEILING, 1, 20, 0),
      mk(1, 17, 5, rtm_pkg::MODE_CEILING, 1, 15, 0),
      mk(0, 17, 5, rtm_pkg::MODE_FLOOR, 1, 15, 0),
      mk(1, 17, 5, rtm_pkg::MODE_FLOOR, 1, 20, 0),
      mk(0, 15, 10, rtm_pkg::MODE_HALF_DOWN, 1, 10, 0),
      mk(0, 15, 10, rtm_pkg::MODE_HALF_UP, 1, 20, 0),
      mk(0, 15, 10, rtm_pkg::MODE_HALF_EVEN, 1, 20, 0),
      mk(0, 25, 10, rtm_pkg::MODE_HALF_EVEN, 1, 20, 0),
      mk(0, 25, 10, rtm_pkg::MODE_DEFAULT, 1, 20, 0),
      mk(0, 7, 3, rtm_pkg::MODE_HALF_DOWN, 1, 6, 0),
      mk(0, 52, 10, rtm_pkg::MODE_05UP, 1, 60, 0),
      mk(0, 62, 10, rtm_pkg::MODE_05UP, 1, 60, 0),
      mk(0, 2, 10, rtm_pkg::MODE_05UP, 1, 10, 0),
      mk(0, max64, 3, rtm_pkg::MODE_UP),
      mk(1, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB, rtm_pkg::MODE_HALF_UP),
      mk(0, max64, max64 - 1, rtm_pkg::MODE_CEILING)
    };
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_table[i]) send_beat(dir_table[i]);
    tx_idle_on = 0;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) rx_holdoff = 1;
      if (i == 300) begin
        in_tvalid <= 0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (i == 150) tx_idle_on = 1;
      send_beat(rand_beat());
    end
    in_tvalid <= 0;
    stim_done = 1;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rx_holdoff) begin
        out_tready <= 0;
        repeat (200) @(posedge clk);
        rx_holdoff = 0;
      end
      out_tready <= (rx_idle_on && n_sent > 400) ? ($urandom_range(99) >= 29) :
                    (n_sent < 60 ? ($urandom_range(99) >= 29) : 1'b1);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_tdata, 64'(0));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.rounded) report_mismatch("rounded", out_tdata, want.rounded);
        if (out_tuser !== want.wrapped) report_mismatch("wrapped", 64'(out_tuser),
                                                        64'(want.wrapped));
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no beat accepted for %0d cycles", WDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    wait (stim_done);
    wait (pending_results.size() == 0);
    repeat (LAT + 10) @(posedge clk);
    $display("Sent %0d input beats (table of %0d plus random) and checked %0d results,",
             n_sent, dir_table.size(), n_checked);
    $display("covering all modes, unknown codes, zero quantum, wraps and back-pressure.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+sv
sv/rtm_pkg.sv
sv/rtm_div.sv
sv/round_to_multiple_modes.sv
sim/tb_round_to_multiple_modes.sv
